// File: rtl/assert_macros.svh
// Assertion macros used by the RTL of the tokenizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a condition at every rising clock edge outside reset.
`define MST_ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Checks that a condition implies another one in the same cycle.
`define MST_ASSERT_IMPLY(lbl, cond, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

`endif

// File: rtl/mst_pkg.sv
// Shared types, token kinds and the keyword table of the tokenizer.
package mst_pkg;

   localparam int NUM_WORDS = 25;

   // Token kinds.
   localparam logic [4:0] K_EOF    = 5'd0;
   localparam logic [4:0] K_NUMBER = 5'd1;
   localparam logic [4:0] K_SYMBOL = 5'd2;
   localparam logic [4:0] K_FLAGS  = 5'd3;
   localparam logic [4:0] K_CHAR   = 5'd4;
   localparam logic [4:0] K_INC    = 5'd5;
   localparam logic [4:0] K_REG    = 5'd6;
   localparam logic [4:0] K_COND   = 5'd7;
   localparam logic [4:0] K_FUNC   = 5'd8;
   localparam logic [4:0] K_FETCH  = 5'd9;
   localparam logic [4:0] K_GOTO   = 5'd10;
   localparam logic [4:0] K_RETURN = 5'd11;
   localparam logic [4:0] K_IF     = 5'd12;
   localparam logic [4:0] K_ELSE   = 5'd13;
   localparam logic [4:0] K_PC     = 5'd14;
   localparam logic [4:0] K_SR     = 5'd15;
   localparam logic [4:0] K_SL     = 5'd16;
   localparam logic [4:0] K_ERROR  = 5'd17;

   typedef logic [NUM_WORDS-1:0] kw_mask_type;

   typedef struct packed {
      logic       hit;
      logic [4:0] kind;
      logic [3:0] code;
   } kw_result_type;

   // Word text, right aligned: the last character sits in the low byte.
   function automatic logic [47:0] kw_text(input logic [4:0] k);
      case (k)
         5'd0:    kw_text = 48'("func");
         5'd1:    kw_text = 48'("fetch");
         5'd2:    kw_text = 48'("goto");
         5'd3:    kw_text = 48'("return");
         5'd4:    kw_text = 48'("if");
         5'd5:    kw_text = 48'("else");
         5'd6:    kw_text = 48'("A");
         5'd7:    kw_text = 48'("X");
         5'd8:    kw_text = 48'("Y");
         5'd9:    kw_text = 48'("PCL");
         5'd10:   kw_text = 48'("PCH");
         5'd11:   kw_text = 48'("PC");
         5'd12:   kw_text = 48'("AL");
         5'd13:   kw_text = 48'("AH");
         5'd14:   kw_text = 48'("D");
         5'd15:   kw_text = 48'("S");
         5'd16:   kw_text = 48'("P");
         5'd17:   kw_text = 48'("SR");
         5'd18:   kw_text = 48'("SL");
         5'd19:   kw_text = 48'("C");
         5'd20:   kw_text = 48'("N");
         5'd21:   kw_text = 48'("Z");
         5'd22:   kw_text = 48'("V");
         5'd23:   kw_text = 48'("IRQ");
         5'd24:   kw_text = 48'("ALUC");
         default: kw_text = 48'h0;
      endcase
   endfunction

   function automatic logic [2:0] kw_len(input logic [4:0] k);
      case (k)
         5'd0, 5'd2, 5'd5, 5'd24:                    kw_len = 3'd4;
         5'd1:                                       kw_len = 3'd5;
         5'd3:                                       kw_len = 3'd6;
         5'd4, 5'd11, 5'd12, 5'd13, 5'd17, 5'd18:    kw_len = 3'd2;
         5'd9, 5'd10, 5'd23:                         kw_len = 3'd3;
         5'd6, 5'd7, 5'd8, 5'd14, 5'd15, 5'd16,
         5'd19, 5'd20, 5'd21, 5'd22:                 kw_len = 3'd1;
         default:                                    kw_len = 3'd0;
      endcase
   endfunction

   function automatic logic [4:0] kw_kind(input logic [4:0] k);
      case (k)
         5'd0:    kw_kind = K_FUNC;
         5'd1:    kw_kind = K_FETCH;
         5'd2:    kw_kind = K_GOTO;
         5'd3:    kw_kind = K_RETURN;
         5'd4:    kw_kind = K_IF;
         5'd5:    kw_kind = K_ELSE;
         5'd11:   kw_kind = K_PC;
         5'd17:   kw_kind = K_SR;
         5'd18:   kw_kind = K_SL;
         5'd19, 5'd20, 5'd21, 5'd22, 5'd23, 5'd24: kw_kind = K_COND;
         default: kw_kind = K_REG;
      endcase
   endfunction

   function automatic logic [3:0] kw_code(input logic [4:0] k);
      case (k)
         5'd6:    kw_code = 4'd1;
         5'd7:    kw_code = 4'd2;
         5'd8:    kw_code = 4'd3;
         5'd9:    kw_code = 4'd4;
         5'd10:   kw_code = 4'd5;
         5'd12:   kw_code = 4'd6;
         5'd13:   kw_code = 4'd7;
         5'd14:   kw_code = 4'd8;
         5'd15:   kw_code = 4'd9;
         5'd16:   kw_code = 4'd10;
         5'd20:   kw_code = 4'd1;
         5'd21:   kw_code = 4'd2;
         5'd22:   kw_code = 4'd3;
         5'd23:   kw_code = 4'd4;
         5'd24:   kw_code = 4'd5;
         default: kw_code = 4'd0;
      endcase
   endfunction

   // Character of a word at a position, zero past its end.
   function automatic logic [7:0] kw_char(input logic [4:0] k, input logic [2:0] pos);
      logic [47:0] t;
      int          sh;
      t       = kw_text(k);
      kw_char = 8'h00;
      if (pos < kw_len(k)) begin
         sh      = 8 * (int'(kw_len(k)) - 1 - int'(pos));
         kw_char = t[sh +: 8];
      end
   endfunction

endpackage

// File: rtl/microcode_source_tokenizer_core.sv
// Top level of the microcode source tokenizer.
//
// The request channel carries one source byte per transfer (req_character)
// or an end-of-input mark (req_end_of_input). The response channel carries
// tokens: kind, 64-bit value and a last flag that closes each text run.
// Most bytes are scanned once. A byte that the scanner must look at twice
// is stepped again from its held copy: one that ends a number, a word, a
// bare zero or a lone plus, an octal digit right after a leading zero, and
// an end mark that flushes a pending token before the eof token. A symbol
// or flags text run is read back from the text buffer memory byte by byte
// (a synchronous read, then an output load); no byte is accepted meanwhile,
// and a symbol run is followed by one more step for the byte that ended it.
// Each token is presented on the response ports in the cycle after the
// step that makes it. One response register parts the two channels; when
// the receiver stalls, work stops only once a new token needs that register.
// Reset returns the scanner to idle with an empty token; no clearing pass is
// needed. Words longer than TEXT_DEPTH-1 letters, overlong flag lists and an
// end inside a flag list give an error token, after which the block accepts
// and drops every byte until reset.
module microcode_source_tokenizer_core
   import mst_pkg::*;
#(
   parameter int TEXT_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_character,
   input  logic        req_end_of_input,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_kind,
   output logic [63:0] rsp_value,
   output logic        rsp_last
);

`include "assert_macros.svh"

   localparam int LEN_W = $clog2(TEXT_DEPTH);

   // Controller states.
   localparam logic [1:0] C_READY = 2'd0;
   localparam logic [1:0] C_STEP  = 2'd1;
   localparam logic [1:0] C_DRD   = 2'd2;
   localparam logic [1:0] C_DOUT  = 2'd3;

   // Scan modes.
   localparam logic [2:0] M_IDLE    = 3'd0;
   localparam logic [2:0] M_COMMENT = 3'd1;
   localparam logic [2:0] M_ZERO    = 3'd2;
   localparam logic [2:0] M_NUMBER  = 3'd3;
   localparam logic [2:0] M_WORD    = 3'd4;
   localparam logic [2:0] M_FLAGS   = 3'd5;
   localparam logic [2:0] M_PLUS    = 3'd6;
   localparam logic [2:0] M_HALT    = 3'd7;

   // Outcome of one step.
   localparam logic [1:0] N_DONE  = 2'd0;
   localparam logic [1:0] N_CONT  = 2'd1;
   localparam logic [1:0] N_DRAIN = 2'd2;

   localparam logic [4:0] BASE_2  = 5'd2;
   localparam logic [4:0] BASE_8  = 5'd8;
   localparam logic [4:0] BASE_10 = 5'd10;
   localparam logic [4:0] BASE_16 = 5'd16;

   function automatic logic is_space(input logic [7:0] c);
      is_space = (c == 8'h20) || ((c >= 8'd9) && (c <= 8'd13));
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      is_alpha = ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
   endfunction

   function automatic logic [4:0] digit_value(input logic [7:0] c);
      digit_value = 5'd16;
      if ((c >= "0") && (c <= "9")) digit_value = 5'(c - "0");
      else if ((c >= "a") && (c <= "f")) digit_value = 5'(c - "a" + 8'd10);
      else if ((c >= "A") && (c <= "F")) digit_value = 5'(c - "A" + 8'd10);
   endfunction

   logic [1:0]       ctl_ff, ctl_in;
   logic [2:0]       mode_ff, mode_in;
   logic [4:0]       base_ff, base_in;
   logic [63:0]      acc_ff, acc_in;
   logic [LEN_W-1:0] len_ff, len_in;
   kw_mask_type      cand_ff, cand_in;
   logic [7:0]       chr_ff, chr_in;
   logic             end_ff, end_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic [4:0]       dkind_ff, dkind_in;
   logic             dcont_ff, dcont_in;
   logic [7:0]       rd_data_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [4:0]       rsp_kind_ff, rsp_kind_in;
   logic [63:0]      rsp_value_ff, rsp_value_in;
   logic             rsp_last_ff, rsp_last_in;

   logic [7:0]       text_mem [TEXT_DEPTH];

   logic [7:0]       cur_c;
   logic             cur_end;
   logic             out_free, step_active, step_fire, dout_fire, out_load;
   logic             s_emit, s_wr;
   logic [4:0]       s_kind;
   logic [63:0]      s_value;
   logic [1:0]       s_next;
   logic [2:0]       s_mode;
   logic [4:0]       s_base;
   logic [63:0]      s_acc;
   logic [LEN_W-1:0] s_len, s_wr_addr;
   kw_mask_type      s_cand;
   logic [4:0]       s_dkind;
   logic             s_dcont;
   logic [4:0]       dig;
   logic [63:0]      acc_next;
   kw_mask_type      nar_mask, nar_next;
   logic [LEN_W-1:0] nar_pos;
   kw_result_type    fin_result;
   logic             drain_last;

   // The byte under work comes straight from the port when ready.
   assign cur_c   = (ctl_ff == C_READY) ? req_character : chr_ff;
   assign cur_end = (ctl_ff == C_READY) ? req_end_of_input : end_ff;

   assign nar_mask = (mode_ff == M_IDLE) ? '1 : cand_ff;
   assign nar_pos  = (mode_ff == M_IDLE) ? '0 : len_ff;

   mst_kwmatch #(.LEN_W(LEN_W)) u_kwmatch (
      .nar_mask   (nar_mask),
      .nar_pos    (nar_pos),
      .nar_char   (cur_c),
      .nar_next   (nar_next),
      .fin_mask   (cand_ff),
      .fin_len    (len_ff),
      .fin_result (fin_result)
   );

   // Next number value for the current base.
   assign dig = digit_value(cur_c);
   always_comb begin
      case (base_ff)
         BASE_16: acc_next = {acc_ff[59:0], 4'h0} + 64'(dig);
         BASE_8:  acc_next = {acc_ff[60:0], 3'h0} + 64'(dig);
         BASE_2:  acc_next = {acc_ff[62:0], 1'b0} + 64'(dig);
         default: acc_next = {acc_ff[60:0], 3'h0} + {acc_ff[62:0], 1'b0} + 64'(dig);
      endcase
   end

   // One scan step on the current byte and mode.
   always_comb begin
      s_emit    = 1'b0;
      s_kind    = K_EOF;
      s_value   = 64'h0;
      s_next    = N_DONE;
      s_mode    = mode_ff;
      s_base    = base_ff;
      s_acc     = acc_ff;
      s_len     = len_ff;
      s_cand    = cand_ff;
      s_wr      = 1'b0;
      s_wr_addr = len_ff;
      s_dkind   = K_SYMBOL;
      s_dcont   = 1'b1;
      if (mode_ff == M_HALT) begin
         s_next = N_DONE;
      end else if (cur_end) begin
         case (mode_ff)
            M_ZERO, M_NUMBER: begin
               s_emit  = 1'b1;
               s_kind  = K_NUMBER;
               s_value = acc_ff;
               s_mode  = M_IDLE;
               s_next  = N_CONT;
            end
            M_WORD: begin
               s_mode = M_IDLE;
               if (fin_result.hit) begin
                  s_emit  = 1'b1;
                  s_kind  = fin_result.kind;
                  s_value = 64'(fin_result.code);
                  s_next  = N_CONT;
               end else begin
                  s_next = N_DRAIN;
               end
            end
            M_FLAGS: begin
               s_emit = 1'b1;
               s_kind = K_ERROR;
               s_mode = M_HALT;
            end
            M_PLUS: begin
               s_emit  = 1'b1;
               s_kind  = K_CHAR;
               s_value = 64'("+");
               s_mode  = M_IDLE;
               s_next  = N_CONT;
            end
            default: begin
               s_emit = 1'b1;
               s_kind = K_EOF;
               s_mode = M_IDLE;
            end
         endcase
      end else begin
         case (mode_ff)
            M_IDLE: begin
               if (is_space(cur_c)) begin
                  s_next = N_DONE;
               end else if (cur_c == "#") begin
                  s_mode = M_COMMENT;
               end else if ((cur_c >= "0") && (cur_c <= "9")) begin
                  s_acc  = 64'(cur_c - "0");
                  s_base = BASE_10;
                  s_mode = (cur_c == "0") ? M_ZERO : M_NUMBER;
               end else if (is_alpha(cur_c)) begin
                  s_wr      = 1'b1;
                  s_wr_addr = '0;
                  s_len     = LEN_W'(1);
                  s_cand    = nar_next;
                  s_mode    = M_WORD;
               end else if (cur_c == "<") begin
                  s_len  = '0;
                  s_mode = M_FLAGS;
               end else if (cur_c == "_") begin
                  s_emit = 1'b1;
                  s_kind = K_REG;
               end else if (cur_c == "+") begin
                  s_mode = M_PLUS;
               end else begin
                  s_emit  = 1'b1;
                  s_kind  = K_CHAR;
                  s_value = 64'(cur_c);
               end
            end
            M_COMMENT: begin
               if (cur_c == 8'h0A) s_mode = M_IDLE;
            end
            M_ZERO: begin
               if ((cur_c == "x") || (cur_c == "b")) begin
                  s_base = (cur_c == "x") ? BASE_16 : BASE_2;
                  s_mode = M_NUMBER;
               end else if ((cur_c >= "0") && (cur_c <= "7")) begin
                  s_base = BASE_8;
                  s_mode = M_NUMBER;
                  s_next = N_CONT;
               end else begin
                  s_emit  = 1'b1;
                  s_kind  = K_NUMBER;
                  s_value = 64'h0;
                  s_mode  = M_IDLE;
                  s_next  = N_CONT;
               end
            end
            M_NUMBER: begin
               if (dig < base_ff) begin
                  s_acc = acc_next;
               end else begin
                  s_emit  = 1'b1;
                  s_kind  = K_NUMBER;
                  s_value = acc_ff;
                  s_mode  = M_IDLE;
                  s_next  = N_CONT;
               end
            end
            M_WORD: begin
               if (is_alpha(cur_c)) begin
                  if (len_ff >= LEN_W'(TEXT_DEPTH - 1)) begin
                     s_emit = 1'b1;
                     s_kind = K_ERROR;
                     s_mode = M_HALT;
                  end else begin
                     s_cand = nar_next;
                     s_wr   = 1'b1;
                     s_len  = len_ff + LEN_W'(1);
                  end
               end else begin
                  s_mode = M_IDLE;
                  if (fin_result.hit) begin
                     s_emit  = 1'b1;
                     s_kind  = fin_result.kind;
                     s_value = 64'(fin_result.code);
                     s_next  = N_CONT;
                  end else begin
                     s_next = N_DRAIN;
                  end
               end
            end
            M_FLAGS: begin
               if (cur_c == ">") begin
                  s_mode = M_IDLE;
                  if (len_ff == '0) begin
                     s_emit  = 1'b1;
                     s_kind  = K_FLAGS;
                     s_value = 64'h100;
                  end else begin
                     s_next  = N_DRAIN;
                     s_dkind = K_FLAGS;
                     s_dcont = 1'b0;
                  end
               end else if (len_ff >= LEN_W'(TEXT_DEPTH - 1)) begin
                  s_emit = 1'b1;
                  s_kind = K_ERROR;
                  s_mode = M_HALT;
               end else if (!is_space(cur_c)) begin
                  s_wr  = 1'b1;
                  s_len = len_ff + LEN_W'(1);
               end
            end
            M_PLUS: begin
               s_mode = M_IDLE;
               s_emit = 1'b1;
               if (cur_c == "+") begin
                  s_kind = K_INC;
               end else begin
                  s_kind  = K_CHAR;
                  s_value = 64'("+");
                  s_next  = N_CONT;
               end
            end
            default: s_next = N_DONE;
         endcase
      end
   end

   // Handshake and step firing.
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign step_active = ((ctl_ff == C_READY) && req_valid) || (ctl_ff == C_STEP);
   assign step_fire   = step_active && (!s_emit || out_free);
   assign dout_fire   = (ctl_ff == C_DOUT) && out_free;
   assign out_load    = (step_fire && s_emit) || dout_fire;
   assign req_stall   = !((ctl_ff == C_READY) && (!s_emit || out_free));
   assign drain_last  = (idx_ff == (len_ff - LEN_W'(1)));

   // Next values of the scanner and controller.
   always_comb begin
      ctl_in   = ctl_ff;
      mode_in  = mode_ff;
      base_in  = base_ff;
      acc_in   = acc_ff;
      len_in   = len_ff;
      cand_in  = cand_ff;
      chr_in   = chr_ff;
      end_in   = end_ff;
      idx_in   = idx_ff;
      dkind_in = dkind_ff;
      dcont_in = dcont_ff;
      if (step_fire) begin
         mode_in = s_mode;
         base_in = s_base;
         acc_in  = s_acc;
         len_in  = s_len;
         cand_in = s_cand;
         chr_in  = cur_c;
         end_in  = cur_end;
         case (s_next)
            N_CONT:  ctl_in = C_STEP;
            N_DRAIN: begin
               ctl_in   = C_DRD;
               idx_in   = '0;
               dkind_in = s_dkind;
               dcont_in = s_dcont;
            end
            default: ctl_in = C_READY;
         endcase
      end else if (ctl_ff == C_DRD) begin
         ctl_in = C_DOUT;
      end else if (dout_fire) begin
         if (drain_last) begin
            ctl_in = dcont_ff ? C_STEP : C_READY;
         end else begin
            idx_in = idx_ff + LEN_W'(1);
            ctl_in = C_DRD;
         end
      end
   end

   // Response register contents.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_kind_in  = rsp_kind_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      if (dout_fire) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = dkind_ff;
         rsp_value_in = 64'(rd_data_ff);
         rsp_last_in  = drain_last;
      end else if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = s_kind;
         rsp_value_in = s_value;
         rsp_last_in  = 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff       <= C_READY;
         mode_ff      <= M_IDLE;
         base_ff      <= BASE_10;
         acc_ff       <= 64'h0;
         len_ff       <= '0;
         cand_ff      <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         ctl_ff       <= ctl_in;
         mode_ff      <= mode_in;
         base_ff      <= base_in;
         acc_ff       <= acc_in;
         len_ff       <= len_in;
         cand_ff      <= cand_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      chr_ff       <= chr_in;
      end_ff       <= end_in;
      idx_ff       <= idx_in;
      dkind_ff     <= dkind_in;
      dcont_ff     <= dcont_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Text buffer: one write port during scanning, one registered read port.
   always_ff @(posedge clock) begin
      if (step_fire && s_wr) begin
         text_mem[s_wr_addr] <= cur_c;
      end
      if (ctl_ff == C_DRD) begin
         rd_data_ff <= text_mem[idx_ff];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind  = rsp_kind_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_last  = rsp_last_ff;

   `MST_ASSERT_IMPLY(a_halt_silent, mode_ff == M_HALT, !out_load, "token produced after halt")
   `MST_ASSERT_IMPLY(a_read_in_range, ctl_ff == C_DRD, idx_ff < len_ff, "text read past length")
   `MST_ASSERT_IMPLY(a_drain_idle, ctl_ff == C_DOUT, mode_ff == M_IDLE, "drain outside idle mode")
   `MST_ASSERT_ALWAYS(a_load_free, !out_load || out_free, "response register overwritten")

endmodule

// File: rtl/mst_kwmatch.sv
// Keyword table matcher: narrows the candidate set and finds the finished word.
module mst_kwmatch
   import mst_pkg::*;
#(
   parameter int LEN_W = 6
) (
   input  kw_mask_type   nar_mask,
   input  logic [LEN_W-1:0] nar_pos,
   input  logic [7:0]    nar_char,
   output kw_mask_type   nar_next,
   input  kw_mask_type   fin_mask,
   input  logic [LEN_W-1:0] fin_len,
   output kw_result_type fin_result
);

   // Keep the words whose character at this position matches.
   always_comb begin
      for (int k = 0; k < NUM_WORDS; k++) begin
         nar_next[k] = nar_mask[k] && (nar_pos < LEN_W'(kw_len(5'(k)))) &&
                       (nar_char == kw_char(5'(k), nar_pos[2:0]));
      end
   end

   // The first remaining word of full length is the match.
   always_comb begin
      fin_result = '0;
      for (int k = NUM_WORDS - 1; k >= 0; k--) begin
         if (fin_mask[k] && (fin_len == LEN_W'(kw_len(5'(k))))) begin
            fin_result.hit  = 1'b1;
            fin_result.kind = kw_kind(5'(k));
            fin_result.code = kw_code(5'(k));
         end
      end
   end

endmodule
